// ===== sv/isl_pkg.sv =====
// Shared types and constants for the indexed shift list.
// Holds the operation and status codes and the control word broadcast to the cells.
// No dependencies.
package isl_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned CAPACITY_DEF = 64;
    // Number of cells in one leaf group of the read-out tree.
    localparam int unsigned GROUP_SIZE   = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control broadcast to every cell for one request. At most one flag is set.
    typedef struct packed {
        logic ins;   // place the new word at pos, shift later entries up
        logic rem;   // drop the word at pos, shift later entries down
        logic rd;    // present the word at pos to the read-out tree
    } cell_ctrl_t;

endpackage

// ===== sv/isl_cell.sv =====
// One storage cell of the indexed shift list.
// Holds one entry and trades it with its neighbours on insert and remove.
// Depends on isl_pkg.
module isl_cell #(
    parameter int unsigned POS   = 0,
    parameter int unsigned IDX_W = 7
) (
    input  logic                       clk,
    input  isl_pkg::cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           pos,
    input  logic [isl_pkg::WORD_W-1:0] value,
    input  logic [isl_pkg::WORD_W-1:0] left,
    input  logic [isl_pkg::WORD_W-1:0] right,
    output logic [isl_pkg::WORD_W-1:0] word,
    output logic [isl_pkg::WORD_W-1:0] hit
);
    import isl_pkg::*;

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] hit_reg, hit_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.ins)
        begin
            if (MY_POS == pos)
            begin
                word_next = value;
            end
            else if (MY_POS > pos)
            begin
                word_next = left;
            end
        end
        else if (ctrl.rem && (MY_POS >= pos))
        begin
            word_next = right;
        end
    end

    // Only the addressed cell puts its word forward, so the tree can simply OR.
    assign hit_next = (ctrl.rd && (MY_POS == pos)) ? word_reg : '0;

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        hit_reg  <= hit_next;
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

// ===== sv/isl_group_or.sv =====
// First level of the read-out tree: ORs the cell outputs in groups.
// Each group result is registered and held while the load enable is low.
// Depends on isl_pkg.
module isl_group_or #(
    parameter int unsigned N      = 64,
    parameter int unsigned GROUPS = 2
) (
    input  logic                       clk,
    input  logic                       load,
    input  logic [isl_pkg::WORD_W-1:0] leaf [N],
    output logic [isl_pkg::WORD_W-1:0] group_word [GROUPS]
);
    import isl_pkg::*;

    logic [WORD_W-1:0] group_reg  [GROUPS];
    logic [WORD_W-1:0] group_next [GROUPS];

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < N)
                begin
                    group_next[g] = group_next[g] | leaf[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            group_reg <= group_next;
        end
    end

    assign group_word = group_reg;

endmodule

// ===== sv/indexed_shift_list.sv =====
// Indexed shift list: an ordered list of up to CAPACITY signed 32-bit words held in a row of
// cells. Each request (tuser: append, insert, remove or get) yields exactly one result with
// the word read, the new count and a status. Insert and remove shift every later entry by
// one place in the same cycle, since each cell loads from its neighbour. On a request the
// addressed cell registers its word, then a two-level OR tree over the cells (groups of 32
// registered, then the groups) brings it to the output register once any waiting result
// is taken. A new request is accepted only after the previous one has loaded its result;
// a waiting result does not block the next request.
// Depends on isl_pkg, isl_cell and isl_group_or.
module indexed_shift_list #(
    parameter int unsigned CAPACITY = isl_pkg::CAPACITY_DEF,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1),
    parameter int unsigned S_DATA_W = ((isl_pkg::WORD_W + CNT_W + 7) / 8) * 8,
    parameter int unsigned M_DATA_W = ((isl_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value [31:0], index, zero fill
    input  logic [1:0]          s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // data [31:0], count, zero fill
    output logic [1:0]          m_tuser    // status
);
    import isl_pkg::*;

    localparam int unsigned GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEAF,
        S_GROUP
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  res_cnt_reg;
    status_t           res_st_reg, st_next;
    logic              m_valid_reg;
    logic [WORD_W-1:0] m_data_reg;
    logic [CNT_W-1:0]  m_cnt_reg;
    status_t           m_st_reg;

    logic              accept;
    logic              out_load;
    op_t               op;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  pos;
    cell_ctrl_t        ctrl;
    logic              full;

    logic [WORD_W-1:0] words [CAPACITY];
    logic [WORD_W-1:0] hits  [CAPACITY];
    logic [WORD_W-1:0] group_word [GROUPS];
    logic [WORD_W-1:0] final_word;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign value    = s_tdata[WORD_W-1:0];
    assign idx      = s_tdata[WORD_W+CNT_W-1:WORD_W];
    assign full     = (cnt_reg == CAP_CNT);

    // Decode the request into one cell action; appending is an insert at the count.
    always_comb
    begin
        ctrl     = '0;
        pos      = idx;
        st_next  = ST_DONE;
        cnt_next = cnt_reg;
        case (op)
            OP_APPEND:
            begin
                pos = cnt_reg;
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    ctrl.ins = accept;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (idx > cnt_reg)
                begin
                    st_next = ST_RANGE;
                end
                else if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    ctrl.ins = accept;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (idx >= cnt_reg)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    ctrl.rem = accept;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_GET:
            begin
                if (idx >= cnt_reg)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    ctrl.rd = accept;
                end
            end
            default:
            begin
                st_next = ST_DONE;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w, right_w;
        if (i == 0)
        begin : g_first
            assign left_w = value;
        end
        else
        begin : g_mid_l
            assign left_w = words[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = words[i];
        end
        else
        begin : g_mid_r
            assign right_w = words[i+1];
        end
        isl_cell #(
            .POS   (i),
            .IDX_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .pos   (pos),
            .value (value),
            .left  (left_w),
            .right (right_w),
            .word  (words[i]),
            .hit   (hits[i])
        );
    end

    isl_group_or #(
        .N      (CAPACITY),
        .GROUPS (GROUPS)
    ) u_group_or (
        .clk        (clk),
        .load       (state_reg == S_LEAF),
        .leaf       (hits),
        .group_word (group_word)
    );

    always_comb
    begin
        final_word = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            final_word = final_word | group_word[g];
        end
    end

    assign out_load = (state_reg == S_GROUP) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                state_next = S_GROUP;
            end
            S_GROUP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_cnt_reg <= cnt_next;
            res_st_reg  <= st_next;
        end
        if (out_load)
        begin
            m_data_reg <= final_word;
            m_cnt_reg  <= res_cnt_reg;
            m_st_reg   <= res_st_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_cnt_reg, m_data_reg});
    assign m_tuser  = m_st_reg;

endmodule

// ===== sv/isl_checker.sv =====
// Port-level checks for the indexed shift list, bound to the top level.
// Depends on isl_pkg and indexed_shift_list.
module isl_checker #(
    parameter int unsigned CAPACITY = isl_pkg::CAPACITY_DEF,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1),
    parameter int unsigned S_DATA_W = ((isl_pkg::WORD_W + CNT_W + 7) / 8) * 8,
    parameter int unsigned M_DATA_W = ((isl_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [1:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser
);
    import isl_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before its transfer");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while one is in progress");

    // A result with an error status carries a zero word.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata[WORD_W-1:0] == '0))
        else $error("error result carries data");

    // The reported count never exceeds the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[WORD_W+CNT_W-1:WORD_W] <= CAP_CNT))
        else $error("count above capacity");

endmodule

bind indexed_shift_list isl_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .S_DATA_W (S_DATA_W),
    .M_DATA_W (M_DATA_W)
) u_isl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
